### rtl/apig_pkg.sv
package apig_pkg;

    // Datapath width of all range arithmetic
    localparam int DataW = 64;
    // Step counter width for one pass over DataW bits
    localparam int CntW = $clog2(DataW);

    // Configuration register indexes
    localparam logic [2:0] CFG_ARMED = 3'd0;
    localparam logic [2:0] CFG_START = 3'd1;
    localparam logic [2:0] CFG_SIZE  = 3'd2;
    localparam logic [2:0] CFG_MULT  = 3'd3;
    localparam logic [2:0] CFG_INCR  = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOCFG     = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    // (a + b) mod m for a, b < m
    function automatic logic [DataW-1:0] mod_add(
        input logic [DataW-1:0] a,
        input logic [DataW-1:0] b,
        input logic [DataW-1:0] m
    );
        logic [DataW:0] s;
        logic [DataW:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, m};
        return (s >= {1'b0, m}) ? d[DataW-1:0] : s[DataW-1:0];
    endfunction

endpackage

### rtl/apig_modred.sv
// Bit-serial restoring remainder: dividend mod modulus, one dividend bit
// per cycle, MSB first. Modulus must be nonzero.
module apig_modred (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [apig_pkg::DataW-1:0] i_dividend,
    input  logic [apig_pkg::DataW-1:0] i_modulus,
    output logic                      o_done,
    output logic [apig_pkg::DataW-1:0] o_rem
);

    localparam logic [apig_pkg::CntW-1:0] LastStep = apig_pkg::CntW'(apig_pkg::DataW - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [apig_pkg::CntW-1:0]   r_cnt;
    logic [apig_pkg::DataW-1:0]  r_shift;
    logic [apig_pkg::DataW-1:0]  r_rem;
    logic [apig_pkg::DataW:0]    n_trial;
    logic [apig_pkg::DataW:0]    n_diff;

    // Shift in the next dividend bit and subtract the modulus when it fits
    always_comb begin
        n_trial = {r_rem, r_shift[apig_pkg::DataW-1]};
        n_diff  = n_trial - {1'b0, i_modulus};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastStep) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shift register and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[apig_pkg::DataW-2:0], 1'b0};
            r_rem   <= (n_trial >= {1'b0, i_modulus}) ? n_diff[apig_pkg::DataW-1:0]
                                                      : n_trial[apig_pkg::DataW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### rtl/apig_modmul.sv
// Bit-serial modular multiply: (a * b) mod m by shift-and-add, one
// multiplier bit per cycle, LSB first. Requires a, b < m.
module apig_modmul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [apig_pkg::DataW-1:0] i_a,
    input  logic [apig_pkg::DataW-1:0] i_b,
    input  logic [apig_pkg::DataW-1:0] i_m,
    output logic                       o_done,
    output logic [apig_pkg::DataW-1:0] o_prod
);

    localparam logic [apig_pkg::CntW-1:0] LastStep = apig_pkg::CntW'(apig_pkg::DataW - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [apig_pkg::CntW-1:0]   r_cnt;
    logic [apig_pkg::DataW-1:0]  r_bits;
    logic [apig_pkg::DataW-1:0]  r_acc;
    logic [apig_pkg::DataW-1:0]  r_addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastStep) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Add the doubled addend for each set multiplier bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bits   <= i_b;
            r_acc    <= '0;
            r_addend <= i_a;
        end else if (r_busy) begin
            r_bits   <= {1'b0, r_bits[apig_pkg::DataW-1:1]};
            if (r_bits[0]) begin
                r_acc <= apig_pkg::mod_add(r_acc, r_addend, i_m);
            end
            r_addend <= apig_pkg::mod_add(r_addend, r_addend, i_m);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### rtl/affine_permutation_index_generator.sv
// A served request passes S_MUL, the one-bit-per-cycle modular multiply, then S_FINAL
// and S_EMIT into the output register; the first after a config write first passes
// S_REDUCE for the serial reduction of multiplier and increment by the size.
// Error requests go straight to S_EMIT and from there to the output register, which
// waits while the output is stalled. One item is in work at a time; a request of 0 is taken every idle cycle.
// Reset (synchronous, active low): count 0, armed 0, start 0, size 1, mult 1, incr 0.
module affine_permutation_index_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [apig_pkg::DataW-1:0] i_cfg_data,
    // request channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_request,
    // result channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [apig_pkg::DataW-1:0] o_value,
    output logic [1:0]                 o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_MUL,
        S_FINAL,
        S_EMIT
    } t_state;

    t_state                      r_state;
    logic                        r_armed;
    logic [apig_pkg::DataW-1:0]  r_start;
    logic [apig_pkg::DataW-1:0]  r_size;
    logic [apig_pkg::DataW-1:0]  r_mult;
    logic [apig_pkg::DataW-1:0]  r_incr;
    logic [apig_pkg::DataW-1:0]  r_count;
    logic                        r_red_ok;
    logic [apig_pkg::DataW-1:0]  r_mult_red;
    logic [apig_pkg::DataW-1:0]  r_incr_red;
    logic                        r_red_start;
    logic                        r_mul_start;
    logic [apig_pkg::DataW-1:0]  r_res_value;
    logic [1:0]                  r_res_status;
    logic                        r_out_valid;
    logic [apig_pkg::DataW-1:0]  r_out_value;
    logic [1:0]                  r_out_status;

    logic                        mred_done;
    logic [apig_pkg::DataW-1:0]  mred_rem;
    logic                        ired_done;
    logic [apig_pkg::DataW-1:0]  ired_rem;
    logic                        mul_done;
    logic [apig_pkg::DataW-1:0]  mul_prod;

    // Serial reduction of multiplier and increment by the range size
    apig_modred u_mult_red (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_red_start),
        .i_dividend (r_mult),
        .i_modulus  (r_size),
        .o_done     (mred_done),
        .o_rem      (mred_rem)
    );

    apig_modred u_incr_red (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_red_start),
        .i_dividend (r_incr),
        .i_modulus  (r_size),
        .o_done     (ired_done),
        .o_rem      (ired_rem)
    );

    // Serial count * multiplier mod size
    apig_modmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_count),
        .i_b     (r_mult_red),
        .i_m     (r_size),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Sequencer, configuration registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_armed      <= 1'b0;
            r_start      <= '0;
            r_size       <= apig_pkg::DataW'(1);
            r_mult       <= apig_pkg::DataW'(1);
            r_incr       <= '0;
            r_count      <= '0;
            r_red_ok     <= 1'b0;
            r_red_start  <= 1'b0;
            r_mul_start  <= 1'b0;
            r_res_status <= apig_pkg::ST_OK;
            r_out_valid  <= 1'b0;
        end else begin
            r_red_start <= 1'b0;
            r_mul_start <= 1'b0;

            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && i_request) begin
                        if (!r_armed) begin
                            r_res_status <= apig_pkg::ST_NOCFG;
                            r_state      <= S_EMIT;
                        end else if (r_size == '0 || r_count >= r_size) begin
                            r_res_status <= apig_pkg::ST_EXHAUSTED;
                            r_state      <= S_EMIT;
                        end else if (r_red_ok) begin
                            r_mul_start <= 1'b1;
                            r_state     <= S_MUL;
                        end else begin
                            r_red_start <= 1'b1;
                            r_state     <= S_REDUCE;
                        end
                    end
                end
                S_REDUCE: begin
                    if (mred_done && ired_done) begin
                        r_mult_red  <= mred_rem;
                        r_incr_red  <= ired_rem;
                        r_red_ok    <= 1'b1;
                        r_mul_start <= 1'b1;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    r_res_value  <= apig_pkg::mod_add(mul_prod, r_incr_red, r_size);
                    r_res_status <= apig_pkg::ST_OK;
                    r_count      <= r_count + 1'b1;
                    r_state      <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_value  <= (r_res_status == apig_pkg::ST_OK)
                                        ? r_start + r_res_value : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // Configuration writes; any listed register clears the count
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    apig_pkg::CFG_ARMED: r_armed <= i_cfg_data[0];
                    apig_pkg::CFG_START: r_start <= i_cfg_data;
                    apig_pkg::CFG_SIZE:  r_size  <= i_cfg_data;
                    apig_pkg::CFG_MULT:  r_mult  <= i_cfg_data;
                    apig_pkg::CFG_INCR:  r_incr  <= i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index <= apig_pkg::CFG_INCR) begin
                    r_count  <= '0;
                    r_red_ok <= 1'b0;
                end
            end
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

    // Error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != apig_pkg::ST_OK) |-> (o_value == '0))
        else $error("error result with nonzero value");

    // Status code is always a defined one
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == apig_pkg::ST_OK || o_status == apig_pkg::ST_NOCFG ||
                     o_status == apig_pkg::ST_EXHAUSTED))
        else $error("undefined status code");

    // Count saturates at the range size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_size)
        else $error("issued count beyond range size");

    // Multiply only runs on reduced operands
    a_mul_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> r_red_ok)
        else $error("multiply started without reduced operands");

    // A successful result advances the count by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && !i_cfg_we) |=> (r_count == $past(r_count) + 1'b1))
        else $error("count did not advance");

endmodule
